>>> src/assert_macros.svh
// assertion macros shared by the field of view check rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/fovc_pkg.sv
// types, constants and tables for the field of view check
package fovc_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 12;
   localparam int TABLE_LEN     = 24;
   localparam int TABLE_IDX_W   = $clog2(TABLE_LEN);
   localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   localparam int POS_W     = 16;
   localparam int ANG_W     = 16;
   localparam int OFS_W     = POS_W + 1;
   localparam int XY_W      = OFS_W + FRAC_BITS + 2;
   localparam int ACC_W     = 32;
   localparam int GAIN_W    = 24;
   localparam int PROD_W    = XY_W - 1 + GAIN_W;
   localparam int DIST_W    = 17;
   localparam int DIST_RAW_W = PROD_W + 1 - GAIN_W - FRAC_BITS;
   localparam int HALF_AP_W = 15;
   localparam int RANGE_W   = 16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [GAIN_W-1:0] INV_GAIN       = GAIN_W'(10188014);
   localparam logic [ACC_W-1:0]  ACC_HALF_TURN  = ACC_W'(32'h8000_0000);
   localparam logic [ACC_W-1:0]  BEARING_ROUND  = ACC_W'(32'h0000_8000);
   localparam logic [PROD_W:0]   DIST_ROUND     = (PROD_W + 1)'(1) << (GAIN_W - 1 + FRAC_BITS);
   localparam logic [DIST_W-1:0] DIST_MAX       = '1;

   localparam logic [HALF_AP_W-1:0] HALF_AP_RESET = HALF_AP_W'(8192);
   localparam logic [RANGE_W-1:0]   RANGE_RESET   = RANGE_W'(4096);

   // atan(2^-i), 2^32 per full turn
   localparam logic [ACC_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic {
      REG_HALF_APERTURE = 1'b0,
      REG_RANGE_LIMIT   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic [ACC_W-1:0]        acc;
      logic signed [ANG_W-1:0] heading;
   } cordic_type;

   typedef struct packed {
      logic [HALF_AP_W-1:0] half_aperture;
      logic [RANGE_W-1:0]   range_limit;
   } cfg_type;

endpackage

>>> src/fovc_stream_if.sv
// request and response stream interfaces
interface fovc_req_if;
   import fovc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] cam_x;
   logic signed [POS_W-1:0] cam_y;
   logic signed [ANG_W-1:0] cam_heading;
   logic signed [POS_W-1:0] mark_x;
   logic signed [POS_W-1:0] mark_y;

   modport source (output valid, cam_x, cam_y, cam_heading, mark_x, mark_y, input ready);
   modport sink (input valid, cam_x, cam_y, cam_heading, mark_x, mark_y, output ready);
endinterface

interface fovc_rsp_if;
   import fovc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    visible;
   logic [DIST_W-1:0]       distance;
   logic signed [ANG_W-1:0] bearing;

   modport source (output valid, visible, distance, bearing, input ready);
   modport sink (input valid, visible, distance, bearing, output ready);
endinterface

>>> src/fovc_csr.sv
// apb register block for aperture and range
module fovc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fovc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fovc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fovc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output fovc_pkg::cfg_type               cfg
);
   import fovc_pkg::*;

   logic [HALF_AP_W-1:0] half_aperture_ff, half_aperture_in;
   logic [RANGE_W-1:0]   range_limit_ff, range_limit_in;
   logic                 wr_en;
   reg_index_type        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      half_aperture_in = half_aperture_ff;
      range_limit_in   = range_limit_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_HALF_APERTURE: half_aperture_in = csr_pwdata[HALF_AP_W-1:0];
            REG_RANGE_LIMIT:   range_limit_in   = csr_pwdata[RANGE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HALF_APERTURE: csr_prdata = CSR_DATA_W'(half_aperture_ff);
         REG_RANGE_LIMIT:   csr_prdata = CSR_DATA_W'(range_limit_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_aperture_ff <= HALF_AP_RESET;
         range_limit_ff   <= RANGE_RESET;
      end else begin
         half_aperture_ff <= half_aperture_in;
         range_limit_ff   <= range_limit_in;
      end
   end

   assign cfg.half_aperture = half_aperture_ff;
   assign cfg.range_limit   = range_limit_ff;

endmodule

>>> src/fovc_prep.sv
// offset forming and half plane fold ahead of the cordic chain
`include "assert_macros.svh"

module fovc_prep (
   input  logic                 clock,
   input  logic                 reset,
   fovc_req_if.sink             req,
   output logic                 down_valid,
   output fovc_pkg::cordic_type down_data,
   input  logic                 down_ready
);
   import fovc_pkg::*;

   logic                    valid_ff, valid_in;
   cordic_type              data_ff, data_in;
   logic                    advance;
   logic signed [OFS_W-1:0] dx, dy, dx_fold, dy_fold;
   logic                    left_half;

   assign advance   = !valid_ff || down_ready;
   assign req.ready = advance;

   always_comb begin
      dx        = {req.mark_x[POS_W-1], req.mark_x} - {req.cam_x[POS_W-1], req.cam_x};
      dy        = {req.mark_y[POS_W-1], req.mark_y} - {req.cam_y[POS_W-1], req.cam_y};
      left_half = dx[OFS_W-1];
      dx_fold   = left_half ? -dx : dx;
      dy_fold   = left_half ? -dy : dy;
      data_in.x = {{2{dx_fold[OFS_W-1]}}, dx_fold, {FRAC_BITS{1'b0}}};
      data_in.y = {{2{dy_fold[OFS_W-1]}}, dy_fold, {FRAC_BITS{1'b0}}};
      data_in.acc     = left_half ? ACC_HALF_TURN : '0;
      data_in.heading = req.cam_heading;
      valid_in        = advance ? req.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req.valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   `ASSERT_IMPLY(a_prep_x_nonneg, clock, reset, valid_ff, !data_ff.x[XY_W-1])

endmodule

>>> src/fovc_cell.sv
// one vectoring rotation of the cordic chain
`include "assert_macros.svh"

module fovc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fovc_pkg::TABLE_IDX_W-1:0]   stage_idx,
   input  logic                               up_valid,
   input  fovc_pkg::cordic_type               up_data,
   output logic                               up_ready,
   output logic                               down_valid,
   output fovc_pkg::cordic_type               down_data,
   input  logic                               down_ready
);
   import fovc_pkg::*;

   logic                   valid_ff, valid_in;
   cordic_type             data_ff, data_in;
   logic                   advance;
   logic signed [XY_W-1:0] x_cur, y_cur, x_sh, y_sh;

   assign advance  = !valid_ff || down_ready;
   assign up_ready = advance;

   always_comb begin
      x_cur = up_data.x;
      y_cur = up_data.y;
      x_sh  = x_cur >>> stage_idx;
      y_sh  = y_cur >>> stage_idx;
      data_in.heading = up_data.heading;
      if (!y_cur[XY_W-1]) begin
         data_in.x   = x_cur + y_sh;
         data_in.y   = y_cur - x_sh;
         data_in.acc = up_data.acc + ATAN_TABLE[stage_idx];
      end else begin
         data_in.x   = x_cur - y_sh;
         data_in.y   = y_cur + x_sh;
         data_in.acc = up_data.acc - ATAN_TABLE[stage_idx];
      end
      valid_in = advance ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   `ASSERT_NEXT(a_cell_hold_valid, clock, reset, valid_ff && !down_ready, valid_ff)
   `ASSERT_NEXT(a_cell_hold_data, clock, reset, valid_ff && !down_ready, $stable(data_ff))

endmodule

>>> src/fovc_post.sv
// gain removal, rounding and range and aperture window test
module fovc_post (
   input  logic                 clock,
   input  logic                 reset,
   input  fovc_pkg::cfg_type    cfg,
   input  logic                 up_valid,
   input  fovc_pkg::cordic_type up_data,
   output logic                 up_ready,
   fovc_rsp_if.source           rsp
);
   import fovc_pkg::*;

   // multiply stage
   logic                    a_valid_ff, a_valid_in, a_ready;
   logic [PROD_W-1:0]       a_prod_ff, a_prod_in;
   logic [ACC_W-1:0]        a_acc_ff;
   logic signed [ANG_W-1:0] a_heading_ff;
   logic [XY_W-2:0]         x_pos;

   // round stage
   logic                    b_valid_ff, b_valid_in, b_ready;
   logic [DIST_W-1:0]       b_dist_ff, b_dist_in;
   logic [ANG_W-1:0]        b_bearing_ff, b_bearing_in;
   logic [ANG_W-1:0]        b_diff_ff, b_diff_in;
   logic [PROD_W:0]         dist_sum;
   logic [DIST_RAW_W-1:0]   dist_raw;
   logic [ACC_W-1:0]        bearing_sum;

   // window stage
   logic                    c_valid_ff, c_valid_in, c_ready;
   logic                    c_visible_ff, c_visible_in;
   logic [DIST_W-1:0]       c_dist_ff;
   logic [ANG_W-1:0]        c_bearing_ff;
   logic [ANG_W-1:0]        mag;

   assign c_ready  = !c_valid_ff || rsp.ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   always_comb begin
      x_pos      = up_data.x[XY_W-1] ? '0 : up_data.x[XY_W-2:0];
      a_prod_in  = PROD_W'(x_pos) * PROD_W'(INV_GAIN);
      a_valid_in = a_ready ? up_valid : a_valid_ff;
   end

   always_comb begin
      dist_sum     = {1'b0, a_prod_ff} + DIST_ROUND;
      dist_raw     = dist_sum[PROD_W:GAIN_W+FRAC_BITS];
      b_dist_in    = (dist_raw > DIST_RAW_W'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];
      bearing_sum  = a_acc_ff + BEARING_ROUND;
      b_bearing_in = bearing_sum[ACC_W-1:ACC_W-ANG_W];
      b_diff_in    = b_bearing_in - a_heading_ff;
      b_valid_in   = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_comb begin
      mag          = b_diff_ff[ANG_W-1] ? -b_diff_ff : b_diff_ff;
      c_visible_in = (b_dist_ff <= DIST_W'(cfg.range_limit))
                     && (mag < ANG_W'(cfg.half_aperture));
      c_valid_in   = c_ready ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         a_prod_ff    <= a_prod_in;
         a_acc_ff     <= up_data.acc;
         a_heading_ff <= up_data.heading;
      end
      if (b_ready && a_valid_ff) begin
         b_dist_ff    <= b_dist_in;
         b_bearing_ff <= b_bearing_in;
         b_diff_ff    <= b_diff_in;
      end
      if (c_ready && b_valid_ff) begin
         c_visible_ff <= c_visible_in;
         c_dist_ff    <= b_dist_ff;
         c_bearing_ff <= b_bearing_ff;
      end
   end

   assign rsp.valid    = c_valid_ff;
   assign rsp.visible  = c_visible_ff;
   assign rsp.distance = c_dist_ff;
   assign rsp.bearing  = c_bearing_ff;

endmodule

>>> src/field_of_view_check.sv
// field of view check: offset, cordic chain of NUM_STAGES cells, gain removal and window test
// a request passes the prep slice, the cordic cells, then the multiply, round and window slices
// throughput: one request per cycle while responses are taken, every cell and stage is its own register slice
// a stalled response holds only the slices that are full; empty slices keep taking requests
// reset clears all slice valid bits and loads half_aperture 8192 and range_limit 4096
module field_of_view_check (
   input  logic                            clock,
   input  logic                            reset,
   fovc_req_if.sink                        req_ch,
   fovc_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fovc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fovc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fovc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fovc_pkg::*;

   cfg_type    cfg;
   logic       stage_valid [0:NUM_STAGES];
   logic       stage_ready [0:NUM_STAGES];
   cordic_type stage_data  [0:NUM_STAGES];

   fovc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fovc_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .down_valid (stage_valid[0]),
      .down_data  (stage_data[0]),
      .down_ready (stage_ready[0])
   );

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      fovc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_idx  (TABLE_IDX_W'(g)),
         .up_valid   (stage_valid[g]),
         .up_data    (stage_data[g]),
         .up_ready   (stage_ready[g]),
         .down_valid (stage_valid[g+1]),
         .down_data  (stage_data[g+1]),
         .down_ready (stage_ready[g+1])
      );
   end

   fovc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (stage_valid[NUM_STAGES]),
      .up_data  (stage_data[NUM_STAGES]),
      .up_ready (stage_ready[NUM_STAGES]),
      .rsp      (rsp_ch)
   );

endmodule

>>> tb/field_of_view_check_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for field_of_view_check: directed and random requests against a predictor
module field_of_view_check_tb;
   import fovc_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int DRAIN_CYCLES = NUM_STAGES + 14;
   localparam int GAP_PERCENT = 32;
   localparam logic signed [POS_W-1:0] P_MIN = 16'sh8000;
   localparam logic signed [POS_W-1:0] P_MAX = 16'sd32767;

   // atan(2^-i), 2^32 per full turn
   localparam logic [31:0] TURN_ATAN [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };
   localparam longint unsigned UNITY_RECIP = 64'd10188014;

   // a zero offset turns through every stage angle
   localparam logic signed [ANG_W-1:0] ZERO_OFS_BEARING = 16'sd18183;

   typedef struct packed {
      logic signed [POS_W-1:0] cam_x;
      logic signed [POS_W-1:0] cam_y;
      logic signed [ANG_W-1:0] cam_heading;
      logic signed [POS_W-1:0] mark_x;
      logic signed [POS_W-1:0] mark_y;
   } sighting_type;

   typedef struct packed {
      logic                    visible;
      logic [DIST_W-1:0]       distance;
      logic signed [ANG_W-1:0] bearing;
   } view_type;

   typedef struct packed {
      sighting_type sighting;
      logic         typed;
      view_type     want;
   } sighting_row_type;

   localparam view_type NO_VIEW = '{1'b0, 17'd0, 16'sd0};

   // typed rows: marker on camera, with and without the opposite heading
   localparam sighting_row_type SIGHTING_ROWS [0:22] = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{1'b0, 17'd0, ZERO_OFS_BEARING}},
      '{'{16'sd1000, -16'sd2000, P_MIN, 16'sd1000, -16'sd2000}, 1'b1,
        '{1'b0, 17'd0, ZERO_OFS_BEARING}},
      '{'{P_MIN, P_MIN, P_MAX, P_MIN, P_MIN}, 1'b1, '{1'b0, 17'd0, ZERO_OFS_BEARING}},
      '{'{P_MIN, 16'sd0, 16'sd0, P_MAX, 16'sd0}, 1'b0, NO_VIEW},
      '{'{P_MAX, 16'sd0, P_MIN, P_MIN, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, P_MIN, 16'sd16384, 16'sd0, P_MAX}, 1'b0, NO_VIEW},
      '{'{16'sd0, P_MAX, -16'sd16384, 16'sd0, P_MIN}, 1'b0, NO_VIEW},
      '{'{P_MIN, P_MIN, 16'sd8192, P_MAX, P_MAX}, 1'b0, NO_VIEW},
      '{'{P_MAX, P_MAX, -16'sd24576, P_MIN, P_MIN}, 1'b0, NO_VIEW},
      '{'{P_MAX, P_MIN, 16'sd24576, P_MIN, P_MAX}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd4097, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd4096}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, P_MAX, -16'sd4096, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, P_MIN, -16'sd4096, -16'sd1}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, P_MIN, -16'sd4096, 16'sd1}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd8192, 16'sd2896, 16'sd2896}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd2896, 16'sd2896}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd4096}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd1}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, P_MIN, -16'sd1, 16'sd0}, 1'b0, NO_VIEW},
      '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd1}, 1'b0, NO_VIEW}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fovc_req_if req_ch ();
   fovc_rsp_if rsp_ch ();

   field_of_view_check uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [HALF_AP_W-1:0] aperture_setting;
   logic [RANGE_W-1:0]   range_setting;
   view_type             expected_views [$];
   bit                   req_steady;
   bit                   rsp_steady;
   int                   failures;
   int                   views_checked;
   int                   settings_used;
   int                   cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic view_type predict_view(input sighting_type s);
      longint          dx, dy, x, y, xs, ys;
      longint unsigned span;
      logic [31:0]     angle;
      logic [31:0]     rounded;
      logic signed [ANG_W-1:0] off_axis;
      int              mag;
      view_type        v;
      dx = longint'(s.mark_x) - longint'(s.cam_x);
      dy = longint'(s.mark_y) - longint'(s.cam_y);
      angle = 32'd0;
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
         angle = 32'h8000_0000;
      end
      x = dx * (longint'(1) << FRAC_BITS);
      y = dy * (longint'(1) << FRAC_BITS);
      for (int i = 0; i < NUM_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            angle = angle + TURN_ATAN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            angle = angle - TURN_ATAN[i];
         end
      end
      if (x < 0) x = 0;
      span = (longint'(x) * UNITY_RECIP + (64'd1 << (23 + FRAC_BITS))) >> (24 + FRAC_BITS);
      if (span > 64'd131071) span = 64'd131071;
      rounded = angle + 32'h0000_8000;
      v.bearing = rounded[31:16];
      off_axis = v.bearing - s.cam_heading;
      mag = (off_axis < 0) ? -int'(off_axis) : int'(off_axis);
      v.distance = span[DIST_W-1:0];
      v.visible = (span <= longint'(range_setting)) && (mag < int'(aperture_setting));
      return v;
   endfunction

   // random sightings, most placed around the camera, some with the heading near the aperture edge
   function automatic sighting_type random_sighting();
      sighting_type s;
      view_type     aim;
      logic signed [ANG_W-1:0] delta;
      int           spread;
      s.cam_x = 16'($urandom);
      s.cam_y = 16'($urandom);
      if ($urandom_range(99) < 65) begin
         case ($urandom_range(3))
            0: spread = 16;
            1: spread = 2048;
            2: spread = 8192;
            default: spread = 32767;
         endcase
         s.mark_x = s.cam_x + 16'(int'($urandom_range(2 * spread)) - spread);
         s.mark_y = s.cam_y + 16'(int'($urandom_range(2 * spread)) - spread);
      end else begin
         s.mark_x = 16'($urandom);
         s.mark_y = 16'($urandom);
      end
      s.cam_heading = 16'sd0;
      aim = predict_view(s);
      case ($urandom_range(3))
         0: delta = 16'($urandom);
         1: delta = 16'($urandom_range(aperture_setting));
         2: delta = 16'(int'(aperture_setting) + int'($urandom_range(2)) - 1);
         default: delta = P_MIN;
      endcase
      if ($urandom_range(1) == 1) delta = -delta;
      s.cam_heading = aim.bearing - delta;
      return s;
   endfunction

   task automatic send_sighting(input sighting_type s, input logic typed, input view_type want);
      while (!req_steady && $urandom_range(99) < GAP_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cam_x       <= s.cam_x;
      req_ch.cam_y       <= s.cam_y;
      req_ch.cam_heading <= s.cam_heading;
      req_ch.mark_x      <= s.mark_x;
      req_ch.mark_y      <= s.mark_y;
      do @(posedge clock); while (!req_ch.ready);
      expected_views.push_back(typed ? want : predict_view(s));
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_HALF_APERTURE) aperture_setting = value[HALF_AP_W-1:0];
      else range_setting = value[RANGE_W-1:0];
   endtask

   task automatic check_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("csr_prdata: expected %0h, got %0h", want, csr_prdata);
         failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) rsp_ch.ready <= rsp_steady || ($urandom_range(99) >= GAP_PERCENT);

   always @(posedge clock) begin
      view_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_views.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = expected_views.pop_front();
            views_checked++;
            if (rsp_ch.visible !== want.visible) begin
               $error("visible: expected %0d, got %0d", want.visible, rsp_ch.visible);
               failures++;
            end
            if (rsp_ch.distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_ch.distance);
               failures++;
            end
            if (rsp_ch.bearing !== want.bearing) begin
               $error("bearing: expected %0d, got %0d", want.bearing, rsp_ch.bearing);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] aperture_word;
      logic [CSR_DATA_W-1:0] range_word;
      int                    count;
      reset              = 1'b1;
      failures           = 0;
      views_checked      = 0;
      settings_used      = 1;
      req_steady         = 1'b0;
      rsp_steady         = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.cam_x       = '0;
      req_ch.cam_y       = '0;
      req_ch.cam_heading = '0;
      req_ch.mark_x      = '0;
      req_ch.mark_y      = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      aperture_setting   = 15'd8192;
      range_setting      = 16'd4096;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_register(REG_HALF_APERTURE, 32'd8192);
      check_register(REG_RANGE_LIMIT, 32'd4096);

      foreach (SIGHTING_ROWS[i])
         send_sighting(SIGHTING_ROWS[i].sighting, SIGHTING_ROWS[i].typed, SIGHTING_ROWS[i].want);
      req_ch.valid <= 1'b0;

      for (int p = 0; p < 5; p++) begin
         while (expected_views.size() != 0) @(posedge clock);
         case (p)
            0: begin
               aperture_word = 32'hFFFF_8000;
               range_word    = 32'h5A5A_0000;
               count         = 150;
            end
            1: begin
               aperture_word = 32'h0000_7FFF;
               range_word    = 32'h0000_FFFF;
               count         = 200;
            end
            2: begin
               aperture_word = $urandom;
               range_word    = $urandom;
               count         = 200;
            end
            3: begin
               aperture_word = $urandom_range(12000, 1);
               range_word    = $urandom_range(16384, 2048);
               count         = 250;
            end
            default: begin
               aperture_word = 32'hC3C3_4000;
               range_word    = 32'h8001_8000;
               count         = 200;
            end
         endcase
         write_register(REG_HALF_APERTURE, aperture_word);
         write_register(REG_RANGE_LIMIT, range_word);
         check_register(REG_HALF_APERTURE, CSR_DATA_W'(aperture_setting));
         check_register(REG_RANGE_LIMIT, CSR_DATA_W'(range_setting));
         settings_used++;
         req_steady = (p == 1);
         rsp_steady = (p == 1);
         repeat (count) send_sighting(random_sighting(), 1'b0, NO_VIEW);
         req_ch.valid <= 1'b0;
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;

      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests checked under %0d register settings,", views_checked, settings_used);
      $display("including zero and full aperture and range and back-to-back traffic");
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/fovc_pkg.sv
src/fovc_stream_if.sv
src/fovc_csr.sv
src/fovc_prep.sv
src/fovc_cell.sv
src/fovc_post.sv
src/field_of_view_check.sv
tb/field_of_view_check_tb.sv
